### hdl/keyboard_port_registers_defines.svh
`ifndef KEYBOARD_PORT_REGISTERS_DEFINES_SVH
`define KEYBOARD_PORT_REGISTERS_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define KPR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyboard port check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define KPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyboard port check failed");

`endif

### hdl/kpr_pkg.sv
`default_nettype none

package kpr_pkg;

	// request kinds
	localparam logic [2:0] REQ_READ  = 3'd0;
	localparam logic [2:0] REQ_WRITE = 3'd1;
	localparam logic [2:0] REQ_BYTE  = 3'd2;
	localparam logic [2:0] REQ_PRESS = 3'd3;
	localparam logic [2:0] REQ_REL   = 3'd4;
	localparam logic [2:0] REQ_ACK   = 3'd5;

	// register byte offsets
	localparam logic [2:0] OFF_STATUS    = 3'd0;
	localparam logic [2:0] OFF_DATA      = 3'd2;
	localparam logic [2:0] OFF_DATA_HI   = 3'd3;
	localparam logic [2:0] OFF_SCROLL    = 3'd4;
	localparam logic [2:0] OFF_SCROLL_HI = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_MODEL   = 2'd0;
	localparam logic [1:0] CFG_STOP    = 2'd1;
	localparam logic [1:0] CFG_NOTHING = 2'd2;
	localparam logic [1:0] CFG_RESET   = 2'd3;

	localparam logic [7:0] VEC_NORMAL   = 8'o60;
	localparam logic [7:0] VEC_ALT      = 8'o274;
	localparam logic [9:0] SCROLL_RESET = 10'o1330;

	localparam logic [7:0] STOP_RESET    = 8'd0;
	localparam logic [7:0] NOTHING_RESET = 8'd1;
	localparam logic [7:0] RESTART_RESET = 8'd130;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  addr_offset;
		logic [15:0] write_data;
		logic [7:0]  key_code;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        write_refused;
		logic        irq_raise;
		logic [7:0]  irq_vector;
		logic        stop_nmi;
		logic        cpu_restart;
		logic        scroll_changed;
		logic        screen_param_valid;
		logic [3:0]  screen_palette;
		logic        screen_mode_bit;
		logic        timer_enable;
		logic        key_released;
	} rsp_t;

	typedef struct packed {
		logic       model_extended;
		logic [7:0] stop_key_code;
		logic [7:0] nothing_key_code;
		logic [7:0] reset_key_code;
	} cfg_t;

endpackage

`default_nettype wire

### hdl/kpr_cfg.sv
`default_nettype none

module kpr_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_index,
	input  wire logic [7:0]    wr_data,
	output kpr_pkg::cfg_t      cfg
);

	kpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.model_extended   <= 1'b0;
			cfg_q.stop_key_code    <= kpr_pkg::STOP_RESET;
			cfg_q.nothing_key_code <= kpr_pkg::NOTHING_RESET;
			cfg_q.reset_key_code   <= kpr_pkg::RESTART_RESET;
		end else if (wr_en) begin
			case (wr_index)
				kpr_pkg::CFG_MODEL:   cfg_q.model_extended   <= wr_data[0];
				kpr_pkg::CFG_STOP:    cfg_q.stop_key_code    <= wr_data;
				kpr_pkg::CFG_NOTHING: cfg_q.nothing_key_code <= wr_data;
				kpr_pkg::CFG_RESET:   cfg_q.reset_key_code   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/kpr_core.sv
`default_nettype none

module kpr_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire kpr_pkg::req_t req,
	input  wire kpr_pkg::cfg_t cfg,
	output kpr_pkg::rsp_t      rsp
);

	logic       irq_dis_q, ready_q, irq_pend_q, key_up_q, timer_q;
	logic [6:0] key_data_q;
	logic [9:0] scroll_q;

	logic       irq_dis_d, ready_d, irq_pend_d, key_up_d, timer_d;
	logic [6:0] key_data_d;
	logic [9:0] scroll_d;
	logic       scroll_wr;
	logic [9:0] scroll_new;
	logic [7:0] b;
	kpr_pkg::rsp_t r;

	assign b = req.write_data[7:0];

	always_comb begin
		r          = '0;
		irq_dis_d  = irq_dis_q;
		ready_d    = ready_q;
		irq_pend_d = irq_pend_q;
		key_up_d   = key_up_q;
		timer_d    = timer_q;
		key_data_d = key_data_q;
		scroll_wr  = 1'b0;
		scroll_new = scroll_q;

		case (req.req_type)
			kpr_pkg::REQ_READ: begin
				case (req.addr_offset)
					kpr_pkg::OFF_STATUS: r.read_data = {8'd0, ready_q, irq_dis_q, 6'd0};
					kpr_pkg::OFF_DATA: begin
						r.read_data = {9'd0, key_data_q};
						ready_d     = 1'b0;
					end
					kpr_pkg::OFF_SCROLL: r.read_data = {6'd0, scroll_q};
					default: ;
				endcase
			end
			kpr_pkg::REQ_WRITE: begin
				case (req.addr_offset)
					kpr_pkg::OFF_STATUS: irq_dis_d = req.write_data[6];
					kpr_pkg::OFF_DATA: begin
						if (cfg.model_extended) begin
							r.screen_param_valid = 1'b1;
							r.screen_palette     = req.write_data[11:8];
							r.screen_mode_bit    = req.write_data[15];
							timer_d              = ~req.write_data[14];
						end else begin
							r.write_refused = 1'b1;
						end
					end
					kpr_pkg::OFF_SCROLL: begin
						scroll_wr  = 1'b1;
						scroll_new = {req.write_data[9], 1'b0, req.write_data[7:0]};
					end
					default: ;
				endcase
			end
			kpr_pkg::REQ_BYTE: begin
				case (req.addr_offset)
					kpr_pkg::OFF_STATUS: irq_dis_d = b[6];
					kpr_pkg::OFF_DATA:   r.write_refused = 1'b1;
					kpr_pkg::OFF_DATA_HI: begin
						if (cfg.model_extended) begin
							r.screen_param_valid = 1'b1;
							r.screen_palette     = b[3:0];
							r.screen_mode_bit    = b[7];
							timer_d              = ~b[6];
						end else begin
							r.write_refused = 1'b1;
						end
					end
					kpr_pkg::OFF_SCROLL: begin
						scroll_wr  = 1'b1;
						scroll_new = {scroll_q[9], 1'b0, b};
					end
					kpr_pkg::OFF_SCROLL_HI: begin
						// byte bit 1 lands in scroll bit 9
						scroll_wr  = 1'b1;
						scroll_new = {b[1], 1'b0, scroll_q[7:0]};
					end
					default: ;
				endcase
			end
			kpr_pkg::REQ_PRESS: begin
				// priority: stop, then ignored key, then restart
				if (req.key_code == cfg.stop_key_code) begin
					r.stop_nmi = 1'b1;
				end else if (req.key_code == cfg.nothing_key_code) begin
				end else if (req.key_code == cfg.reset_key_code) begin
					r.cpu_restart = 1'b1;
				end else begin
					ready_d    = 1'b1;
					key_data_d = req.key_code[6:0];
					key_up_d   = 1'b0;
					if (!irq_pend_q && !irq_dis_q) begin
						irq_pend_d   = 1'b1;
						r.irq_raise  = 1'b1;
						r.irq_vector = req.key_code[7] ? kpr_pkg::VEC_ALT
						                               : kpr_pkg::VEC_NORMAL;
					end
				end
			end
			kpr_pkg::REQ_REL: key_up_d   = 1'b1;
			kpr_pkg::REQ_ACK: irq_pend_d = 1'b0;
			default: ;
		endcase

		scroll_d         = scroll_new;
		r.scroll_changed = scroll_wr && (scroll_new != scroll_q);
		r.timer_enable   = timer_d;
		r.key_released   = key_up_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_dis_q  <= 1'b0;
			ready_q    <= 1'b0;
			irq_pend_q <= 1'b0;
			key_up_q   <= 1'b1;
			timer_q    <= 1'b0;
			key_data_q <= 7'd0;
			scroll_q   <= kpr_pkg::SCROLL_RESET;
		end else if (en) begin
			irq_dis_q  <= irq_dis_d;
			ready_q    <= ready_d;
			irq_pend_q <= irq_pend_d;
			key_up_q   <= key_up_d;
			timer_q    <= timer_d;
			key_data_q <= key_data_d;
			scroll_q   <= scroll_d;
		end
	end

	assign rsp = r;

endmodule

`default_nettype wire

### hdl/keyboard_port_registers.sv
// Pipeline: a request passes an input register (req_s1), then a result register (rsp_q).
// Throughput: one request per cycle while rsp_stall does not hold the result; the result
//   register frees the input side whenever it is empty or being taken in the same cycle.
// Reset (arst_n low, asynchronous): state resets, data registers do not; no result pending.
`default_nettype none

module keyboard_port_registers (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire kpr_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output kpr_pkg::rsp_t      rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data
);

	kpr_pkg::req_t req_s1;
	logic          vld_s1;
	kpr_pkg::rsp_t rsp_q;
	logic          rsp_vld_q;
	kpr_pkg::rsp_t core_rsp;
	kpr_pkg::cfg_t cfg;
	logic          out_free, adv;

	assign out_free  = !rsp_vld_q || !rsp_stall;
	assign adv       = vld_s1 && out_free;
	assign req_stall = vld_s1 && !out_free;
	assign cfg_ready = 1'b1;

	kpr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kpr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				vld_s1 <= 1'b1;
			else if (adv)
				vld_s1 <= 1'b0;
			if (adv)
				rsp_vld_q <= 1'b1;
			else if (!rsp_stall)
				rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
		if (adv)
			rsp_q <= core_rsp;
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### hdl/kpr_checker.sv
`default_nettype none
`include "keyboard_port_registers_defines.svh"

module kpr_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire kpr_pkg::rsp_t rsp
);

	logic vec_legal, screen_quiet, refuse_alone;

	assign vec_legal    = rsp.irq_vector == kpr_pkg::VEC_NORMAL ||
	                      rsp.irq_vector == kpr_pkg::VEC_ALT;
	assign screen_quiet = rsp.screen_palette == 4'd0 && !rsp.screen_mode_bit;
	assign refuse_alone = !rsp.screen_param_valid && !rsp.irq_raise;

	`KPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`KPR_ASSERT_NOW(a_vec_legal, rsp_valid && rsp.irq_raise, vec_legal)
	`KPR_ASSERT_NOW(a_vec_quiet, rsp_valid && !rsp.irq_raise, rsp.irq_vector == 8'd0)
	`KPR_ASSERT_NOW(a_screen_quiet, rsp_valid && !rsp.screen_param_valid, screen_quiet)
	`KPR_ASSERT_NOW(a_err_excl, rsp_valid && rsp.write_refused, refuse_alone)

endmodule

bind keyboard_port_registers kpr_checker u_kpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
